// ----- rtl/scx_pkg.sv -----
`timescale 1ns / 1ps

package scx_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int MINC_W     = 50;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W - 1;

  localparam logic [MINC_W-1:0] MIN_CROSS_RESET = MINC_W'(1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] path_start_x;
    logic signed [COORD_BITS-1:0] path_start_y;
    logic signed [COORD_BITS-1:0] path_end_x;
    logic signed [COORD_BITS-1:0] path_end_y;
    logic signed [COORD_BITS-1:0] gate_start_x;
    logic signed [COORD_BITS-1:0] gate_start_y;
    logic signed [COORD_BITS-1:0] gate_end_x;
    logic signed [COORD_BITS-1:0] gate_end_y;
  } in_item_t;

  typedef struct packed {
    logic                 crossed;
    logic [FRAC_BITS:0]   path_fraction;
    logic                 dir_positive;
  } out_item_t;

  typedef struct packed {
    logic             crossed;
    logic             neg;
    logic             full;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_item_t;

endpackage

// ----- rtl/scx_div.sv -----
`timescale 1ns / 1ps

module scx_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  scx_pkg::div_item_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output scx_pkg::out_item_t  out_data,
  input  logic                out_stall
);

  localparam int NST = scx_pkg::FRAC_BITS + 1;
  localparam int MW  = scx_pkg::MAG_W;
  localparam int FB  = scx_pkg::FRAC_BITS;

  logic [NST-1:0]          vld_r;
  logic [NST-1:0]          adv;
  logic [NST-1:0]          crossed_r;
  logic [NST-1:0]          neg_r;
  logic [NST-1:0]          full_r;
  logic [MW-1:0]           rem_r [NST];
  logic [MW-1:0]           den_r [NST];
  logic [FB-1:0]           quo_r [NST];

  logic [MW-1:0]           rem_nxt [NST-1];
  logic [FB-1:0]           quo_nxt [NST-1];

  // bubble-collapsing advance chain
  always_comb begin
    adv[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  // one restoring step per stage
  always_comb begin
    logic [MW:0] sh;
    logic [MW:0] diff;
    logic        ge;
    for (int k = 0; k < NST - 1; k++) begin
      sh   = {rem_r[k], 1'b0};
      diff = sh - {1'b0, den_r[k]};
      ge   = sh >= {1'b0, den_r[k]};
      rem_nxt[k] = ge ? diff[MW-1:0] : sh[MW-1:0];
      quo_nxt[k] = {quo_r[k][FB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      crossed_r[0] <= in_data.crossed;
      neg_r[0]     <= in_data.neg;
      full_r[0]    <= in_data.full;
      rem_r[0]     <= in_data.num;
      den_r[0]     <= in_data.den;
      quo_r[0]     <= '0;
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k] && vld_r[k-1]) begin
        crossed_r[k] <= crossed_r[k-1];
        neg_r[k]     <= neg_r[k-1];
        full_r[k]    <= full_r[k-1];
        rem_r[k]     <= rem_nxt[k-1];
        den_r[k]     <= den_r[k-1];
        quo_r[k]     <= quo_nxt[k-1];
      end
    end
  end

  assign out_valid = vld_r[NST-1];

  always_comb begin
    out_data.crossed      = crossed_r[NST-1];
    out_data.dir_positive = crossed_r[NST-1] && neg_r[NST-1];
    if (!crossed_r[NST-1]) begin
      out_data.path_fraction = '0;
    end else if (full_r[NST-1]) begin
      out_data.path_fraction = {1'b1, {FB{1'b0}}};
    end else begin
      out_data.path_fraction = {1'b0, quo_r[NST-1]};
    end
  end

endmodule

// ----- rtl/segment_crossing_test.sv -----
`timescale 1ns / 1ps
// segment crossing test: path segment start->end against gate segment start->end
// input channel: in_valid / in_stall / in_data, one transfer per segment pair
// result channel: out_valid / out_stall / out_data, one transfer per input transfer,
//   in input order; crossed, path fraction (2^16 = 1.0, truncated) and direction
// cfg_we / cfg_wdata write min_cross; write it only while the pipeline is empty
// throughput: one pair per cycle while in_stall is low; the work is 4 arithmetic stages
//   (differences, multipliers, cross subtraction, sign fold) followed by 17 divider stages,
//   the first loading the operands and each later one adding one restoring quotient bit
// stall: out_stall holds the last stage; earlier stages keep filling bubbles, so
//   in_stall rises only once every stage holds an item; nothing is lost or repeated
// reset: synchronous active-low rst_n empties the pipeline and sets min_cross to 1

module segment_crossing_test (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  scx_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output scx_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [scx_pkg::MINC_W-1:0]          cfg_wdata
);

  localparam int CB = scx_pkg::COORD_BITS;
  localparam int DW = scx_pkg::DIFF_W;
  localparam int PW = scx_pkg::PROD_W;
  localparam int XW = scx_pkg::CROSS_W;
  localparam int MW = scx_pkg::MAG_W;

  logic [scx_pkg::MINC_W-1:0] min_cross_r;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic adv_s1, adv_s2, adv_s3, adv_s4;
  logic div_stall;

  logic signed [DW-1:0] rx_r, ry_r, sx_r, sy_r, wx_r, wy_r;
  logic signed [PW-1:0] rx_sy_r, ry_sx_r, wx_sy_r, wy_sx_r, wx_ry_r, wy_rx_r;
  logic signed [XW-1:0] den_r, tn_r, un_r;
  logic [MW-1:0]        mag_r;
  logic signed [XW-1:0] tn4_r, un4_r;
  logic                 neg_r;

  scx_pkg::div_item_t   div_in;
  logic                 den_ok, tn_ok, un_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cross_r <= scx_pkg::MIN_CROSS_RESET;
    end else if (cfg_we) begin
      min_cross_r <= cfg_wdata;
    end
  end

  assign adv_s4   = !s4_vld_r || !div_stall;
  assign adv_s3   = !s3_vld_r || adv_s4;
  assign adv_s2   = !s2_vld_r || adv_s3;
  assign adv_s1   = !s1_vld_r || adv_s2;
  assign in_stall = !adv_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_vld_r <= in_valid;
      end
      if (adv_s2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (adv_s3) begin
        s3_vld_r <= s2_vld_r;
      end
      if (adv_s4) begin
        s4_vld_r <= s3_vld_r;
      end
    end
  end

  // direction vectors
  always_ff @(posedge clk) begin
    if (adv_s1 && in_valid) begin
      rx_r <= {in_data.path_end_x[CB-1], in_data.path_end_x}
            - {in_data.path_start_x[CB-1], in_data.path_start_x};
      ry_r <= {in_data.path_end_y[CB-1], in_data.path_end_y}
            - {in_data.path_start_y[CB-1], in_data.path_start_y};
      sx_r <= {in_data.gate_end_x[CB-1], in_data.gate_end_x}
            - {in_data.gate_start_x[CB-1], in_data.gate_start_x};
      sy_r <= {in_data.gate_end_y[CB-1], in_data.gate_end_y}
            - {in_data.gate_start_y[CB-1], in_data.gate_start_y};
      wx_r <= {in_data.gate_start_x[CB-1], in_data.gate_start_x}
            - {in_data.path_start_x[CB-1], in_data.path_start_x};
      wy_r <= {in_data.gate_start_y[CB-1], in_data.gate_start_y}
            - {in_data.path_start_y[CB-1], in_data.path_start_y};
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv_s2 && s1_vld_r) begin
      rx_sy_r <= rx_r * sy_r;
      ry_sx_r <= ry_r * sx_r;
      wx_sy_r <= wx_r * sy_r;
      wy_sx_r <= wy_r * sx_r;
      wx_ry_r <= wx_r * ry_r;
      wy_rx_r <= wy_r * rx_r;
    end
  end

  // cross products
  always_ff @(posedge clk) begin
    if (adv_s3 && s2_vld_r) begin
      den_r <= {rx_sy_r[PW-1], rx_sy_r} - {ry_sx_r[PW-1], ry_sx_r};
      tn_r  <= {wx_sy_r[PW-1], wx_sy_r} - {wy_sx_r[PW-1], wy_sx_r};
      un_r  <= {wx_ry_r[PW-1], wx_ry_r} - {wy_rx_r[PW-1], wy_rx_r};
    end
  end

  // fold sign so the denominator is positive
  always_ff @(posedge clk) begin
    logic [XW-1:0] den_abs;
    den_abs = den_r[XW-1] ? -den_r : den_r;
    if (adv_s4 && s3_vld_r) begin
      neg_r <= den_r[XW-1];
      mag_r <= den_abs[MW-1:0];
      tn4_r <= den_r[XW-1] ? -tn_r : tn_r;
      un4_r <= den_r[XW-1] ? -un_r : un_r;
    end
  end

  always_comb begin
    den_ok = (mag_r != '0) && (mag_r >= min_cross_r);
    tn_ok  = !tn4_r[XW-1] && (tn4_r[MW-1:0] <= mag_r);
    un_ok  = !un4_r[XW-1] && (un4_r[MW-1:0] <= mag_r);
    div_in.crossed = den_ok && tn_ok && un_ok;
    div_in.neg     = neg_r;
    div_in.full    = tn4_r[MW-1:0] >= mag_r;
    div_in.num     = tn4_r[MW-1:0];
    div_in.den     = mag_r;
  end

  scx_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_vld_r),
    .in_data   (div_in),
    .in_stall  (div_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  a_no_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.crossed |->
      out_data.path_fraction == '0 && !out_data.dir_positive)
    else $error("non-crossing result carries nonzero fields");

  a_fraction_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.path_fraction[scx_pkg::FRAC_BITS] |->
      out_data.path_fraction[scx_pkg::FRAC_BITS-1:0] == '0)
    else $error("path fraction above one");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r)
    else $error("input stalled with a bubble in the front stages");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
